FILE: design/cbpe_pkg.sv
// Shared constants of the cubic Bezier point evaluator: register indexes and port widths.
package cbpe_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int WIDTH_W   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_START_POINT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_POINT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EASE_IN_POINT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EASE_OUT_POINT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_WIDTH      = 3'd5;

  typedef logic [WIDTH_W-1:0] width_t;

endpackage

FILE: design/cubic_bezier_point_evaluator.sv
// Cubic Bezier point evaluator: seven-stage pipeline giving point, width and tangent per t.
//
//   channel  handshake          payload
//   input    start, busy        in_t
//   result   out_valid          out_x, out_y, out_width, out_tangent_x, out_tangent_y
//   config   cfg_we             cfg_index, cfg_wdata
//
// A beat is taken at every edge where start is high; busy stays low, one t per cycle.
// Each result is formed by a clamp register for t and then by the chain of three
// multiply and round-add steps of the point polynomial, each step split over two stages.
// Reset clears the configuration registers and the valid bits of the pipeline.
// The receiver cannot stall, so the pipeline never holds; every beat advances each cycle.
module cubic_bezier_point_evaluator #(
  parameter int COORD_BITS  = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [T_FRAC_BITS:0]              in_t,
  output logic                              out_valid,
  output logic signed [COORD_BITS-1:0]      out_x,
  output logic signed [COORD_BITS-1:0]      out_y,
  output cbpe_pkg::width_t                  out_width,
  output logic signed [COORD_BITS-1:0]      out_tangent_x,
  output logic signed [COORD_BITS-1:0]      out_tangent_y,
  input  logic                              cfg_we,
  input  logic [cbpe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [2*COORD_BITS-1:0]           cfg_wdata
);
  import cbpe_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int TF  = T_FRAC_BITS;
  localparam int TW  = TF + 1;
  localparam int HW  = CB + 5;
  localparam int PW  = HW + TW + 1;
  localparam int DW  = WIDTH_W + 1;
  localparam int PWW = DW + TW + 1;
  localparam int STAGES = 7;

  localparam logic [TW-1:0]           T_ONE   = TW'(1) << TF;
  localparam logic signed [PW-1:0]    HALF    = PW'(1) << (TF - 1);
  localparam logic signed [PWW-1:0]   HALF_W  = PWW'(1) << (TF - 1);
  localparam logic signed [HW-1:0]    SAT_MAX = HW'((64'd1 << (CB - 1)) - 64'd1);
  localparam logic signed [HW-1:0]    SAT_MIN = -SAT_MAX - HW'(1);

  function automatic logic signed [HW-1:0] sext(input logic [CB-1:0] c);
    return {{(HW-CB){c[CB-1]}}, c};
  endfunction

  function automatic logic signed [PW-1:0] mul(input logic signed [HW-1:0] h,
                                               input logic [TW-1:0] t);
    logic signed [PW-1:0] hs;
    logic signed [PW-1:0] ts;
    hs = PW'(h);
    ts = PW'({1'b0, t});
    return hs * ts;
  endfunction

  function automatic logic signed [HW-1:0] rnd(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] s;
    s = (v + HALF) >>> TF;
    return s[HW-1:0];
  endfunction

  function automatic logic signed [CB-1:0] sat(input logic signed [HW-1:0] v);
    logic signed [CB-1:0] r;
    priority if (v > SAT_MAX) begin
      r = SAT_MAX[CB-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[CB-1:0];
    end else begin
      r = v[CB-1:0];
    end
    return r;
  endfunction

  logic [2*CB-1:0] start_pt_r, end_pt_r, ease_in_r, ease_out_r;
  width_t          start_w_r, end_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pt_r <= '0;
      end_pt_r   <= '0;
      ease_in_r  <= '0;
      ease_out_r <= '0;
      start_w_r  <= '0;
      end_w_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_POINT:    start_pt_r <= cfg_wdata;
        REG_END_POINT:      end_pt_r   <= cfg_wdata;
        REG_EASE_IN_POINT:  ease_in_r  <= cfg_wdata;
        REG_EASE_OUT_POINT: ease_out_r <= cfg_wdata;
        REG_START_WIDTH:    start_w_r  <= cfg_wdata[WIDTH_W-1:0];
        REG_END_WIDTH:      end_w_r    <= cfg_wdata[WIDTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Lane 0 is x (upper half of each point), lane 1 is y.
  logic signed [HW-1:0] coef_a [2];
  logic signed [HW-1:0] coef_b [2];
  logic signed [HW-1:0] coef_c [2];
  logic signed [HW-1:0] coef_d [2];
  logic signed [HW-1:0] coef_b2 [2];
  logic signed [HW-1:0] coef_c3 [2];

  always_comb begin
    logic signed [HW-1:0] p0, p1, p2, p3, b3;
    for (int k = 0; k < 2; k++) begin
      p0 = sext(start_pt_r[(1-k)*CB +: CB]);
      p1 = sext(ease_in_r[(1-k)*CB +: CB]);
      p2 = sext(ease_out_r[(1-k)*CB +: CB]);
      p3 = sext(end_pt_r[(1-k)*CB +: CB]);
      b3 = p0 - (p1 <<< 1) + p2;
      coef_d[k]  = p0;
      coef_c3[k] = p1 - p0;
      coef_c[k]  = ((p1 - p0) <<< 1) + (p1 - p0);
      coef_b[k]  = (b3 <<< 1) + b3;
      coef_b2[k] = b3 <<< 1;
      coef_a[k]  = p3 - p0 + (p1 <<< 1) + p1 - (p2 <<< 1) - p2;
    end
  end

  logic signed [DW-1:0] width_diff;
  assign width_diff = $signed({1'b0, end_w_r}) - $signed({1'b0, start_w_r});

  logic [STAGES-1:0] vld_r, vld_nxt;
  assign vld_nxt = {vld_r[STAGES-2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  logic [TW-1:0]           t1_r, t2_r, t3_r, t4_r, t5_r;
  logic signed [PW-1:0]    ma_r [2];
  logic signed [HW-1:0]    h1_r [2];
  logic signed [HW-1:0]    g1_r [2];
  logic signed [PW-1:0]    mh_r [2];
  logic signed [PW-1:0]    mg_r [2];
  logic signed [HW-1:0]    h2_r [2];
  logic signed [CB-1:0]    tan5_r [2];
  logic signed [PW-1:0]    mp_r [2];
  logic signed [CB-1:0]    tan6_r [2];
  logic signed [PWW-1:0]   mw_r;
  width_t                  w3_r, w4_r, w5_r, w6_r;
  logic signed [CB-1:0]    pos7_r [2];
  logic signed [CB-1:0]    tan7_r [2];
  width_t                  w7_r;

  logic signed [PWW-1:0]   mw_nxt;
  width_t                  w3_nxt;

  always_comb begin
    logic signed [PWW-1:0] ds;
    logic signed [PWW-1:0] ts;
    logic signed [PWW-1:0] rs;
    logic signed [DW+1:0]  wsum;
    ds = PWW'(width_diff);
    ts = PWW'({1'b0, t1_r});
    mw_nxt = ds * ts;
    rs = (mw_r + HALF_W) >>> TF;
    wsum = (DW+2)'($signed(rs[DW:0])) + (DW+2)'({2'b00, start_w_r});
    priority if (wsum < 0) begin
      w3_nxt = '0;
    end else if (wsum > (DW+2)'(65535)) begin
      w3_nxt = '1;
    end else begin
      w3_nxt = wsum[WIDTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    t1_r <= (in_t > T_ONE) ? T_ONE : in_t;
    t2_r <= t1_r;
    t3_r <= t2_r;
    t4_r <= t3_r;
    t5_r <= t4_r;
    mw_r <= mw_nxt;
    w3_r <= w3_nxt;
    w4_r <= w3_r;
    w5_r <= w4_r;
    w6_r <= w5_r;
    w7_r <= w6_r;
    for (int k = 0; k < 2; k++) begin
      ma_r[k]   <= mul(coef_a[k], t1_r);
      h1_r[k]   <= rnd(ma_r[k]) + coef_b[k];
      g1_r[k]   <= rnd(ma_r[k]) + coef_b2[k];
      mh_r[k]   <= mul(h1_r[k], t3_r);
      mg_r[k]   <= mul(g1_r[k], t3_r);
      h2_r[k]   <= rnd(mh_r[k]) + coef_c[k];
      tan5_r[k] <= sat(rnd(mg_r[k]) + coef_c3[k]);
      mp_r[k]   <= mul(h2_r[k], t5_r);
      tan6_r[k] <= tan5_r[k];
      pos7_r[k] <= sat(rnd(mp_r[k]) + coef_d[k]);
      tan7_r[k] <= tan6_r[k];
    end
  end

  assign busy          = 1'b0;
  assign out_valid     = vld_r[STAGES-1];
  assign out_x         = pos7_r[0];
  assign out_y         = pos7_r[1];
  assign out_width     = w7_r;
  assign out_tangent_x = tan7_r[0];
  assign out_tangent_y = tan7_r[1];

endmodule
